// ===== design/agd_pkg.sv =====
// Shared types and constants of the accelerometer gesture detector.
`timescale 1ns / 1ps

package agd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_THR = 2'd0;
    localparam logic [1:0] CFG_END_THR   = 2'd1;
    localparam logic [1:0] CFG_CALM_END  = 2'd2;
    localparam logic [1:0] CFG_MIN_LEN   = 2'd3;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 34;

    // Register reset values
    localparam logic [33:0] START_THR_RST = 34'd640000;
    localparam logic [33:0] END_THR_RST   = 34'd4000000;
    localparam logic [7:0]  CALM_END_RST  = 8'd4;
    localparam logic [7:0]  MIN_LEN_RST   = 8'd10;

    // Saturation point of the gesture and calm counters
    localparam logic [7:0] CNT_MAX = 8'hFF;

    // Result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_TRIPLE = 1'b1;

    // Width of one packed history triple
    localparam int unsigned TRIPLE_W = 24;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in_req;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [31:0]        magnitude_squared;
        logic [33:0]        change_squared;
        logic [7:0]         gesture_length;
        logic               last;
    } t_out_req;

endpackage

// ===== design/agd_sq_unit.sv =====
// Shared registered squarer for sample and difference components.
`timescale 1ns / 1ps

module agd_sq_unit (
    input  logic               i_clk,
    input  logic signed [16:0] i_op,
    output logic [31:0]        o_sq
);

    logic signed [33:0] prod;
    logic [31:0]        r_sq;

    // |op| <= 65535, so the square always fits in 32 bits
    assign prod = i_op * i_op;

    always_ff @(posedge i_clk) begin
        r_sq <= prod[31:0];
    end

    assign o_sq = r_sq;

endmodule

// ===== design/agd_hist_ring.sv =====
// History ring memory of clipped triples, with per-row valid bits.
`timescale 1ns / 1ps

module agd_hist_ring #(
    parameter int unsigned DEPTH = 50
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [agd_pkg::TRIPLE_W-1:0]     i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic [agd_pkg::TRIPLE_W-1:0]     o_rd_data
);

    logic [agd_pkg::TRIPLE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]             r_vld;
    logic [agd_pkg::TRIPLE_W-1:0] r_rd_data;
    logic                         r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Rows never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== design/accel_gesture_detector.sv =====
// Top level of the accelerometer gesture detector: sequencer and registers.
`timescale 1ns / 1ps

// Accelerometer gesture detector.
// Input channel: i_in_valid / o_in_stall carry one x,y,z sample request.
// Output channel: o_out_valid / i_out_stall carry result requests: one
// sample report (squared magnitude, squared change) per sample, then,
// when a gesture closes with a length from min_gesture_length up to
// HISTORY_DEPTH-1, one request per replayed history triple, oldest first.
// 'last' marks the final request caused by a sample.
// Steps: accept, six passes through the single shared squarer plus a drain,
// state update, report load; per replayed triple, memory read, output load.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must do so only while idle, which the block itself leaves unenforced.
// o_in_stall is high from acceptance until the last request of the sample
// has been loaded into the output register; the next sample may enter
// while that request still waits there.
// When the receiver stalls, the output register holds its request and the
// sequencer waits at the next load.
// Reset (synchronous, active low) returns the sequencer to idle, clears
// counters, previous sample, ring position and all history rows (by valid
// bits, so no clearing pass), and loads register defaults.

module accel_gesture_detector #(
    parameter int unsigned HISTORY_DEPTH = 50
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  agd_pkg::t_in_req                   i_in_req,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output agd_pkg::t_out_req                  o_out_req,
    input  logic                               i_cfg_we,
    input  logic [agd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [agd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned PW = $clog2(HISTORY_DEPTH);
    localparam logic [PW-1:0] POS_LAST = PW'(HISTORY_DEPTH - 1);
    localparam logic [7:0] DEPTH8 = 8'(HISTORY_DEPTH);
    localparam logic [8:0] DEPTH9 = 9'(HISTORY_DEPTH);
    localparam logic [2:0] STEP_LAST = 3'd6;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_UPD  = 6'b000100,
        S_RPT  = 6'b001000,
        S_RD   = 6'b010000,
        S_RPL  = 6'b100000
    } t_state;

    // floor(v/128) clipped to int8
    function automatic logic [7:0] shrink(input logic signed [15:0] v);
        logic [8:0] q;
        q = v[15:7];
        if (q[8] != q[7]) begin
            shrink = q[8] ? 8'h80 : 8'h7F;
        end else begin
            shrink = q[7:0];
        end
    endfunction

    t_state n_state, r_state;

    // Configuration
    logic [33:0] r_start_thr;
    logic [33:0] r_end_thr;
    logic [7:0]  r_calm_end;
    logic [7:0]  r_min_len;

    // Sample work registers
    agd_pkg::t_in_req   r_smp;
    logic signed [15:0] r_prev_x, r_prev_y, r_prev_z;
    logic [2:0]         r_step;
    logic [31:0]        r_mag;
    logic [33:0]        r_chg;

    // Gesture state
    logic [PW-1:0] r_hp;
    logic [7:0]    r_gc;
    logic [7:0]    r_calm;
    logic [7:0]    r_rec;
    logic          r_replay;

    // Replay walk
    logic [PW-1:0] r_pos;
    logic [7:0]    r_left;

    // Output register
    logic              r_ovalid;
    agd_pkg::t_out_req r_out;

    logic               in_acc;
    logic               out_free;
    logic signed [16:0] sq_op;
    logic [31:0]        sq_res;
    logic [2:0]         acc_idx;
    logic [PW-1:0]      hp_next;
    logic [8:0]         start_sum;
    logic [8:0]         start_wrap;
    logic [PW-1:0]      start_pos;
    logic [PW-1:0]      pos_next;
    logic [7:0]         gc_inc;
    logic [7:0]         calm_inc;
    logic               chg_start;
    logic               chg_calm;
    logic [agd_pkg::TRIPLE_W-1:0] wr_trip;
    logic [agd_pkg::TRIPLE_W-1:0] rd_trip;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign acc_idx  = r_step - 3'd1;

    // Squarer operand: raw x,y,z first, then differences from the prior sample
    always_comb begin
        case (r_step)
            3'd0:    sq_op = {r_smp.accel_x[15], r_smp.accel_x};
            3'd1:    sq_op = {r_smp.accel_y[15], r_smp.accel_y};
            3'd2:    sq_op = {r_smp.accel_z[15], r_smp.accel_z};
            3'd3:    sq_op = {r_smp.accel_x[15], r_smp.accel_x} - {r_prev_x[15], r_prev_x};
            3'd4:    sq_op = {r_smp.accel_y[15], r_smp.accel_y} - {r_prev_y[15], r_prev_y};
            3'd5:    sq_op = {r_smp.accel_z[15], r_smp.accel_z} - {r_prev_z[15], r_prev_z};
            default: sq_op = '0;
        endcase
    end

    agd_sq_unit u_sq (
        .i_clk (i_clk),
        .i_op  (sq_op),
        .o_sq  (sq_res)
    );

    // Ring position arithmetic
    assign hp_next    = (r_hp == POS_LAST) ? '0 : r_hp + PW'(1);
    assign pos_next   = (r_pos == POS_LAST) ? '0 : r_pos + PW'(1);
    assign start_sum  = 9'(r_hp) + DEPTH9 - 9'(r_rec);
    assign start_wrap = (start_sum >= DEPTH9) ? start_sum - DEPTH9 : start_sum;
    assign start_pos  = start_wrap[PW-1:0];

    assign gc_inc    = (r_gc != agd_pkg::CNT_MAX) ? r_gc + 8'd1 : r_gc;
    assign calm_inc  = (r_calm != agd_pkg::CNT_MAX) ? r_calm + 8'd1 : r_calm;
    assign chg_start = r_chg > r_start_thr;
    assign chg_calm  = r_chg < r_end_thr;

    assign wr_trip = {shrink(r_smp.accel_x), shrink(r_smp.accel_y), shrink(r_smp.accel_z)};

    agd_hist_ring #(
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (hp_next),
        .i_wr_data (wr_trip),
        .i_rd_en   (r_state == S_RD),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_trip)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_MUL;
            S_MUL:   if (r_step == STEP_LAST) n_state = S_UPD;
            S_UPD:   n_state = S_RPT;
            S_RPT:   if (out_free) n_state = r_replay ? S_RD : S_IDLE;
            S_RD:    n_state = S_RPL;
            S_RPL:   if (out_free) n_state = (r_left == 8'd1) ? S_IDLE : S_RD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start_thr <= agd_pkg::START_THR_RST;
            r_end_thr   <= agd_pkg::END_THR_RST;
            r_calm_end  <= agd_pkg::CALM_END_RST;
            r_min_len   <= agd_pkg::MIN_LEN_RST;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_hp        <= '0;
            r_gc        <= '0;
            r_calm      <= '0;
            r_rec       <= '0;
            r_replay    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    agd_pkg::CFG_START_THR: r_start_thr <= i_cfg_data;
                    agd_pkg::CFG_END_THR:   r_end_thr   <= i_cfg_data;
                    agd_pkg::CFG_CALM_END:  r_calm_end  <= i_cfg_data[7:0];
                    agd_pkg::CFG_MIN_LEN:   r_min_len   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // Output register fills at a report or triple load, empties on accept
            if ((r_state == S_RPT || r_state == S_RPL) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_UPD: begin
                    r_prev_x <= r_smp.accel_x;
                    r_prev_y <= r_smp.accel_y;
                    r_prev_z <= r_smp.accel_z;
                    r_hp     <= hp_next;
                    if (r_gc == '0) begin
                        r_replay <= 1'b0;
                        if (chg_start) begin
                            r_calm <= '0;
                            r_gc   <= 8'd1;
                        end
                    end else if (chg_calm) begin
                        r_calm <= calm_inc;
                        if (calm_inc == r_calm_end) begin
                            r_rec    <= gc_inc;
                            r_replay <= (gc_inc >= r_min_len) && (gc_inc < DEPTH8);
                            r_gc     <= '0;
                        end else begin
                            r_gc     <= gc_inc;
                            r_replay <= 1'b0;
                        end
                    end else begin
                        r_gc     <= gc_inc;
                        r_replay <= 1'b0;
                        if (r_calm < r_calm_end) begin
                            r_calm <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_smp  <= i_in_req;
                    r_step <= '0;
                    r_mag  <= '0;
                    r_chg  <= '0;
                end
            end
            S_MUL: begin
                r_step <= r_step + 3'd1;
                if (r_step != '0) begin
                    if (acc_idx < 3'd3) begin
                        r_mag <= r_mag + sq_res;
                    end else begin
                        r_chg <= r_chg + 34'(sq_res);
                    end
                end
            end
            S_RPT: begin
                if (out_free) begin
                    r_out.kind              <= agd_pkg::KIND_REPORT;
                    r_out.out_x             <= r_smp.accel_x;
                    r_out.out_y             <= r_smp.accel_y;
                    r_out.out_z             <= r_smp.accel_z;
                    r_out.magnitude_squared <= r_mag;
                    r_out.change_squared    <= r_chg;
                    r_out.gesture_length    <= '0;
                    r_out.last              <= !r_replay;
                    r_pos                   <= start_pos;
                    r_left                  <= r_rec;
                end
            end
            S_RPL: begin
                if (out_free) begin
                    r_out.kind              <= agd_pkg::KIND_TRIPLE;
                    r_out.out_x             <= {{8{rd_trip[23]}}, rd_trip[23:16]};
                    r_out.out_y             <= {{8{rd_trip[15]}}, rd_trip[15:8]};
                    r_out.out_z             <= {{8{rd_trip[7]}}, rd_trip[7:0]};
                    r_out.magnitude_squared <= '0;
                    r_out.change_squared    <= '0;
                    r_out.gesture_length    <= r_rec;
                    r_out.last              <= (r_left == 8'd1);
                    r_pos                   <= pos_next;
                    r_left                  <= r_left - 8'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_req   = r_out;

endmodule

// ===== design/agd_checker.sv =====
// Port-level checker for the gesture detector, bound to the top level.
`timescale 1ns / 1ps

module agd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_stall,
    input logic              i_out_valid,
    input logic              i_out_stall,
    input agd_pkg::t_out_req i_out_req
);

    // A held result request does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_req)))
        else $error("result request changed while stalled");

    // The input stall rises once a sample is accepted, so none follow back to back
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall) |=> i_in_stall)
        else $error("sample accepted back to back");

    // Triples carry no report figures and a nonzero gesture length
    a_triple_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_req.kind == agd_pkg::KIND_TRIPLE) |->
        (i_out_req.magnitude_squared == '0 && i_out_req.change_squared == '0
         && i_out_req.gesture_length != '0))
        else $error("bad triple fields");

    // Reports carry no gesture length
    a_report_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_req.kind == agd_pkg::KIND_REPORT) |->
        (i_out_req.gesture_length == '0))
        else $error("bad report fields");

endmodule

bind accel_gesture_detector agd_checker u_agd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_req   (o_out_req)
);

// ===== tb/sv/tb_accel_gesture_detector.sv =====
// Self-checking testbench for the accelerometer gesture detector.
`timescale 1ns / 1ps

module tb_accel_gesture_detector;

    localparam int HIST_DEPTH  = 50;
    localparam int CFG_SETTLE  = 4;          // idle cycles before a register write
    localparam int END_SETTLE  = 120;        // settle after the longest replay, of 49 triples
    localparam int LONG_HOLD   = 300;        // receiver hold-off for back-pressure
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTS  = 40;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    agd_pkg::t_in_req               i_in_req = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    agd_pkg::t_out_req              o_out_req;
    logic                           i_cfg_we = 1'b0;
    logic [agd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [agd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    accel_gesture_detector #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow state of the detector, mirrored on every accepted request
    // ------------------------------------------------------------------
    logic [33:0]        cfg_start_thr  = agd_pkg::START_THR_RST;
    logic [33:0]        cfg_end_thr    = agd_pkg::END_THR_RST;
    logic [7:0]         cfg_calm_count = agd_pkg::CALM_END_RST;
    logic [7:0]         cfg_min_len    = agd_pkg::MIN_LEN_RST;

    logic signed [15:0] prev_x = '0;
    logic signed [15:0] prev_y = '0;
    logic signed [15:0] prev_z = '0;
    logic signed [7:0]  hist_x [HIST_DEPTH];
    logic signed [7:0]  hist_y [HIST_DEPTH];
    logic signed [7:0]  hist_z [HIST_DEPTH];
    int unsigned        ring_pos   = 0;
    logic [7:0]         open_len   = '0;    // 0: no gesture open
    logic [7:0]         calm_run   = '0;
    logic [7:0]         closed_len = '0;

    initial begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_x[i] = '0;
            hist_y[i] = '0;
            hist_z[i] = '0;
        end
    end

    agd_pkg::t_in_req  pending_samples[$];
    agd_pkg::t_out_req expected_results[$];

    // Stimulus bookkeeping
    logic signed [15:0] last_x = '0;
    logic signed [15:0] last_y = '0;
    logic signed [15:0] last_z = '0;
    int   queued_total  = 0;
    int   error_count   = 0;
    int   result_count  = 0;
    int   cycle_count   = 0;
    int   in_gap        = 0;
    int   out_gap       = 0;
    int   hold_count    = 0;
    logic idle_on       = 1'b0;
    logic hold_go       = 1'b0;

    // floor(v / 128) clipped to the int8 range
    function automatic logic signed [7:0] shrink_axis(input logic signed [15:0] v);
        logic signed [15:0] q;
        q = v >>> 7;
        if (q > 16'sd127)
            return 8'h7F;
        if (q < -16'sd128)
            return 8'h80;
        return q[7:0];
    endfunction

    function automatic longint sq_diff(input logic signed [15:0] a, input logic signed [15:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    // Works out every result a sample request causes and queues them in order
    function automatic void predict_sample(input agd_pkg::t_in_req s);
        agd_pkg::t_out_req r;
        longint            mag;
        longint            chg;
        logic              replay;
        int unsigned       pos;
        mag = sq_diff(s.accel_x, 16'sd0) + sq_diff(s.accel_y, 16'sd0)
            + sq_diff(s.accel_z, 16'sd0);
        chg = sq_diff(s.accel_x, prev_x) + sq_diff(s.accel_y, prev_y)
            + sq_diff(s.accel_z, prev_z);
        prev_x = s.accel_x;
        prev_y = s.accel_y;
        prev_z = s.accel_z;

        ring_pos = (ring_pos + 1) % HIST_DEPTH;
        hist_x[ring_pos] = shrink_axis(s.accel_x);
        hist_y[ring_pos] = shrink_axis(s.accel_y);
        hist_z[ring_pos] = shrink_axis(s.accel_z);

        replay = 1'b0;
        if (open_len == 0) begin
            if (chg > longint'(cfg_start_thr)) begin
                calm_run = '0;
                open_len = 8'd1;
            end
        end else begin
            if (open_len < agd_pkg::CNT_MAX)
                open_len++;
            if (chg < longint'(cfg_end_thr)) begin
                if (calm_run < agd_pkg::CNT_MAX)
                    calm_run++;
                // a calm count already past its end value never matches again
                if (calm_run == cfg_calm_count) begin
                    closed_len = open_len;
                    replay = (open_len >= cfg_min_len) && (open_len < HIST_DEPTH);
                    open_len = '0;
                end
            end else if (calm_run < cfg_calm_count) begin
                calm_run = '0;
            end
        end

        r = '0;
        r.kind              = agd_pkg::KIND_REPORT;
        r.out_x             = s.accel_x;
        r.out_y             = s.accel_y;
        r.out_z             = s.accel_z;
        r.magnitude_squared = mag[31:0];
        r.change_squared    = chg[33:0];
        r.last              = !replay;
        expected_results.push_back(r);

        // Replay window: oldest triple predates the gesture, newest is skipped
        if (replay) begin
            pos = (ring_pos + HIST_DEPTH - closed_len) % HIST_DEPTH;
            for (int i = 0; i < closed_len; i++) begin
                r = '0;
                r.kind           = agd_pkg::KIND_TRIPLE;
                r.out_x          = hist_x[pos];
                r.out_y          = hist_y[pos];
                r.out_z          = hist_z[pos];
                r.gesture_length = closed_len;
                r.last           = (i == closed_len - 1);
                expected_results.push_back(r);
                pos = (pos + 1) % HIST_DEPTH;
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
            $display("cycle %0d result %0d: %s", cycle_count, result_count, msg);
        error_count++;
    endtask

    task automatic check_result(input agd_pkg::t_out_req got);
        agd_pkg::t_out_req want;
        if (expected_results.size() == 0) begin
            report_mismatch("result arrived with nothing expected");
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.out_x !== want.out_x)
            report_mismatch($sformatf("out_x %0d, expected %0d", got.out_x, want.out_x));
        if (got.out_y !== want.out_y)
            report_mismatch($sformatf("out_y %0d, expected %0d", got.out_y, want.out_y));
        if (got.out_z !== want.out_z)
            report_mismatch($sformatf("out_z %0d, expected %0d", got.out_z, want.out_z));
        if (got.magnitude_squared !== want.magnitude_squared)
            report_mismatch($sformatf("magnitude_squared %0d, expected %0d",
                                      got.magnitude_squared, want.magnitude_squared));
        if (got.change_squared !== want.change_squared)
            report_mismatch($sformatf("change_squared %0d, expected %0d",
                                      got.change_squared, want.change_squared));
        if (got.gesture_length !== want.gesture_length)
            report_mismatch($sformatf("gesture_length %0d, expected %0d",
                                      got.gesture_length, want.gesture_length));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask

    // ------------------------------------------------------------------
    // Sender: one request held until accepted, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_sample(i_in_req);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap != 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    i_in_req   <= pending_samples.pop_front();
                    i_in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 3) == 0)
                        in_gap = $urandom_range(1, 11);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering
    always @(posedge i_clk) begin
        if (hold_go)
            hold_count <= LONG_HOLD;
        else if (hold_count != 0)
            hold_count <= hold_count - 1;
    end

    // ------------------------------------------------------------------
    // Receiver: checks each accepted result, stalls for the long hold-off and, while idle_on is set, in random bursts
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_result(o_out_req);
                result_count++;
            end
            if (hold_count != 0) begin
                i_out_stall <= 1'b1;
            end else if (out_gap != 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (idle_on && $urandom_range(0, 4) == 0)
                    out_gap = $urandom_range(1, 11);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers: these fill the queues only at the falling edge
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic int jitter(input int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    task automatic queue_sample(input int x, input int y, input int z);
        agd_pkg::t_in_req s;
        s.accel_x = clip16(x);
        s.accel_y = clip16(y);
        s.accel_z = clip16(z);
        pending_samples.push_back(s);
        last_x = s.accel_x;
        last_y = s.accel_y;
        last_z = s.accel_z;
        queued_total++;
    endtask

    task automatic queue_noise(input int count);
        for (int i = 0; i < count; i++)
            queue_sample(int'($urandom_range(0, 65535)) - 32768,
                         int'($urandom_range(0, 65535)) - 32768,
                         int'($urandom_range(0, 65535)) - 32768);
    endtask

    // A jump that opens a gesture, swinging motion, then a calm tail.
    // Length when the thresholds suit: 1 + moves + calms.
    task automatic queue_gesture(input int moves, input int calms);
        int bx, by, bz;
        int cx, cy, cz;
        int swing;
        // jump at least 4000 in x away from the last sample
        bx = (last_x >= 0) ? -int'($urandom_range(4000, 16000))
                           : int'($urandom_range(4000, 16000));
        by = int'($urandom_range(0, 32000)) - 16000;
        bz = int'($urandom_range(0, 32000)) - 16000;
        queue_sample(bx, by, bz);
        for (int i = 0; i < moves; i++) begin
            swing = (i % 2 == 0) ? 8000 : -8000;
            queue_sample(bx + swing + jitter(1000), by - swing + jitter(1000),
                         bz + jitter(1000));
        end
        cx = last_x;
        cy = last_y;
        cz = last_z;
        for (int i = 0; i < calms; i++)
            queue_sample(cx + jitter(150), cy + jitter(150), cz + jitter(150));
    endtask

    // Mostly well-formed gestures with random content, some broken or noise
    task automatic queue_mix(input int count);
        int stop;
        stop = queued_total + count;
        while (queued_total < stop) begin
            if ($urandom_range(0, 9) < 7)
                queue_gesture($urandom_range(0, 20), $urandom_range(1, 6));
            else
                queue_noise($urandom_range(1, 4));
        end
    endtask

    task automatic wait_idle(input int settle);
        while (pending_samples.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [agd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [agd_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            agd_pkg::CFG_START_THR: cfg_start_thr  = value;
            agd_pkg::CFG_END_THR:   cfg_end_thr    = value;
            agd_pkg::CFG_CALM_END:  cfg_calm_count = value[7:0];
            agd_pkg::CFG_MIN_LEN:   cfg_min_len    = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(input logic [33:0] start_thr, input logic [33:0] calm_thr,
                                 input logic [7:0] calm_count, input logic [7:0] min_len);
        write_register(agd_pkg::CFG_START_THR, start_thr);
        write_register(agd_pkg::CFG_END_THR, calm_thr);
        write_register(agd_pkg::CFG_CALM_END, {26'd0, calm_count});
        write_register(agd_pkg::CFG_MIN_LEN, {26'd0, min_len});
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idle_on = 1'b1;

        // Directed, reset register values: zero sample, change exactly at the
        // start threshold (no gesture), full-scale extremes, clipping and
        // rounding of the history shift, a gesture too short to replay, then
        // one of exactly the minimum length that replays ten triples.
        queue_sample(0, 0, 0);
        queue_sample(800, 0, 0);
        queue_sample(32767, 32767, 32767);
        queue_sample(-32768, -32768, -32768);
        queue_sample(16383, -16384, 16384);
        queue_sample(-1, 127, -128);
        queue_sample(-129, 128, 255);
        for (int i = 0; i < 4; i++)
            queue_sample(-129, 128, 255);
        queue_gesture(5, 4);
        wait_idle(CFG_SETTLE);

        // Random gestures; the receiver holds off early so the block backs up
        set_registers(34'd1000000, 34'd2000000, 8'd3, 8'd5);
        queue_mix(20);
        hold_go = 1'b1;
        @(negedge i_clk);
        hold_go = 1'b0;
        wait_idle(CFG_SETTLE);

        // Every change opens, every next sample closes: two-triple replays,
        // plus two repeated samples that must not open anything
        set_registers('0, '1, 8'd1, 8'd0);
        idle_on = 1'b0;
        queue_noise(6);
        queue_sample(last_x, last_y, last_z);
        queue_sample(last_x, last_y, last_z);
        queue_noise(3);
        wait_idle(CFG_SETTLE);

        // Calm count of zero: every sample is calm, yet the gesture stays open
        set_registers('0, '1, 8'd0, 8'd0);
        idle_on = 1'b1;
        queue_noise(6);
        wait_idle(CFG_SETTLE);

        // Calm count now past its end value: samples that are not calm
        // leave it standing and the gesture stays open
        set_registers(34'd640000, '0, 8'd3, 8'd0);
        queue_noise(4);
        wait_idle(CFG_SETTLE);

        // Calm again: the count climbs onto a higher end value and closes
        set_registers('0, '1, 8'd7, 8'd0);
        queue_noise(1);
        wait_idle(CFG_SETTLE);

        // Never opens, never calm
        set_registers('1, '0, 8'd4, 8'd255);
        queue_noise(6);
        wait_idle(CFG_SETTLE);

        // Around the history depth, flat out with no idling: 49 replays in
        // full, 50 does not
        set_registers(34'd640000, 34'd4000000, 8'd1, 8'd49);
        idle_on = 1'b0;
        queue_gesture(47, 1);
        queue_gesture(48, 1);
        wait_idle(END_SETTLE);

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/agd_pkg.sv
design/agd_sq_unit.sv
design/agd_hist_ring.sv
design/accel_gesture_detector.sv
design/agd_checker.sv
tb/sv/tb_accel_gesture_detector.sv
